// ===== hdl/fss_pkg.sv =====
// Shared constants, payload types and sequencer states for the sample statistics block.
`timescale 1ns / 1ps
package fss_pkg;

	localparam int NODE_W = 32;
	localparam int CNT_W  = 16;
	localparam int TIME_W = 24;
	localparam int FILT_W = 5;
	localparam int SUM_W  = CNT_W + TIME_W;
	localparam int VAR_W  = 2 * TIME_W;
	localparam int SQS_W  = CNT_W + VAR_W;
	localparam int PROD_W = CNT_W + SQS_W;
	localparam int DIV_W  = 2 * CNT_W;
	localparam int ITER_W = $clog2(PROD_W + 1);

	typedef struct packed {
		logic [NODE_W-1:0] node_count;
		logic [TIME_W-1:0] sample_time;
		logic              batch_end;
	} in_t;

	typedef struct packed {
		logic [CNT_W-1:0]  sample_count;
		logic [TIME_W-1:0] mean_time;
		logic [TIME_W-1:0] max_time;
		logic [TIME_W-1:0] min_time;
		logic [TIME_W-1:0] std_dev_time;
		logic              has_samples;
		logic              count_saturated;
	} out_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ACC,
		S_ADD,
		S_STAT,
		S_MUL_A,
		S_MUL_B,
		S_SUB,
		S_MUL_C,
		S_DIV,
		S_SQRT,
		S_DONE
	} state_t;

	function automatic logic [FILT_W-1:0] flog2(input logic [NODE_W-1:0] v);
		logic [FILT_W-1:0] r;
		r = '0;
		for (int i = 0; i < NODE_W; i++) begin
			if (v[i]) r = FILT_W'(i);
		end
		return r;
	endfunction

endpackage

// ===== hdl/fss_if.sv =====
// Valid/ready channel interfaces for samples, results and the filter register.
`timescale 1ns / 1ps
interface fss_in_if import fss_pkg::*; ();
	logic valid;
	logic ready;
	in_t  data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface fss_out_if import fss_pkg::*; ();
	logic valid;
	logic ready;
	out_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface fss_cfg_if import fss_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [FILT_W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/filtered_sample_statistics_unit.sv =====
// Filtered sample statistics: count, mean, min, max and standard deviation per batch.
//
// Channels: sample_in takes one request {node_count, sample_time, batch_end};
// result_out gives one request per batch; cfg writes the 5-bit log2 filter
// (always ready, write only while the block is idle).
// A sample counts when the filter is 0 or floor(log2(node_count)) equals it.
// Each sample passes accept, accumulate and square-sum add; sample_in
// is ready only in the idle state, so a new sample waits until the last is through.
// A sample with batch_end runs the statistics sequencer on one shared 80-bit
// adder: 80-step divide for the mean, shift-add products count*sumsq (16),
// sum*sum (40), a subtract, count*count (16), an 80-step divide for the
// variance and a 24-step square root.
// An empty batch skips the divide, multiply and root steps and gives an all-zero result.
// The result sits in an output register; new samples are taken while it
// waits. If result_out is still stalled when the next batch finishes, the
// sequencer holds in its last state until the register frees.
// Reset clears the accumulators, the filter and the output valid.
`timescale 1ns / 1ps
module filtered_sample_statistics_unit import fss_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	fss_cfg_if.sink   cfg,
	fss_in_if.sink    sample_in,
	fss_out_if.source result_out
);

	state_t state_q, state_d;

	logic [FILT_W-1:0] filter_q;
	logic [CNT_W-1:0]  acc_count_q;
	logic [SUM_W-1:0]  acc_sum_q;
	logic [SQS_W-1:0]  acc_sqs_q;
	logic [TIME_W-1:0] acc_max_q;
	logic [TIME_W-1:0] acc_min_q;
	logic              acc_sat_q;
	logic              out_valid_q;
	out_t              out_q;

	logic [NODE_W-1:0] nodes_q;
	logic [TIME_W-1:0] t_q;
	logic              last_q;
	logic [VAR_W-1:0]  sq_q;
	logic              add_q;
	logic [PROD_W-1:0] work_q;
	logic [PROD_W-1:0] aux_q;
	logic [DIV_W-1:0]  rem_q;
	logic [DIV_W-1:0]  dvs_q;
	logic [SUM_W-1:0]  mplr_q;
	logic [ITER_W-1:0] cnt_q;
	logic [TIME_W-1:0] root_q;
	logic [TIME_W-1:0] mean_q;
	logic              var_ph_q;

	logic [PROD_W-1:0] alu_a, alu_b;
	logic              alu_sub;
	logic [PROD_W:0]   alu_res;
	logic              alu_ge;
	logic              last_it;
	logic              match;
	logic              in_fire;
	logic              out_load;
	logic [DIV_W:0]    div_sh;
	logic [DIV_W-1:0]  sqrt_sh;

	assign in_fire  = sample_in.valid && sample_in.ready;
	assign last_it  = (cnt_q == ITER_W'(1));
	assign match    = (filter_q == '0) || (flog2(nodes_q) == filter_q);
	assign out_load = (state_q == S_DONE) && (!out_valid_q || result_out.ready);
	assign div_sh   = {rem_q, work_q[PROD_W-1]};
	assign sqrt_sh  = {rem_q[DIV_W-3:0], work_q[VAR_W-1 -: 2]};

	// shared adder / subtractor
	assign alu_res = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} + (PROD_W+1)'(alu_sub);
	assign alu_ge  = alu_res[PROD_W];

	assign cfg.ready        = 1'b1;
	assign result_out.valid = out_valid_q;
	assign result_out.data  = out_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:  if (in_fire) state_d = S_ACC;
			S_ACC:   state_d = S_ADD;
			S_ADD:   state_d = last_q ? S_STAT : S_IDLE;
			S_STAT:  state_d = (acc_count_q == '0) ? S_DONE : S_DIV;
			S_DIV: begin
				if (last_it) state_d = var_ph_q ? S_SQRT : S_MUL_A;
			end
			S_MUL_A: if (last_it) state_d = S_MUL_B;
			S_MUL_B: if (last_it) state_d = S_SUB;
			S_SUB:   state_d = S_MUL_C;
			S_MUL_C: if (last_it) state_d = S_DIV;
			S_SQRT:  if (last_it) state_d = S_DONE;
			S_DONE:  if (out_load) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// outputs: handshake and adder operands
	always_comb begin
		sample_in.ready = (state_q == S_IDLE);
		alu_a   = '0;
		alu_b   = '0;
		alu_sub = 1'b0;
		case (state_q)
			S_ADD: begin
				alu_a = PROD_W'(acc_sqs_q);
				alu_b = PROD_W'(sq_q);
			end
			S_MUL_A: begin
				alu_a = {work_q[PROD_W-2:0], 1'b0};
				alu_b = mplr_q[SUM_W-1] ? PROD_W'(acc_sqs_q) : '0;
			end
			S_MUL_B: begin
				alu_a = {work_q[PROD_W-2:0], 1'b0};
				alu_b = mplr_q[SUM_W-1] ? PROD_W'(acc_sum_q) : '0;
			end
			S_MUL_C: begin
				alu_a = {work_q[PROD_W-2:0], 1'b0};
				alu_b = mplr_q[SUM_W-1] ? PROD_W'(acc_count_q) : '0;
			end
			S_SUB: begin
				alu_a   = aux_q;
				alu_b   = work_q;
				alu_sub = 1'b1;
			end
			S_DIV: begin
				alu_a   = PROD_W'(div_sh);
				alu_b   = PROD_W'(dvs_q);
				alu_sub = 1'b1;
			end
			S_SQRT: begin
				alu_a   = PROD_W'(sqrt_sh);
				alu_b   = PROD_W'({root_q, 2'b01});
				alu_sub = 1'b1;
			end
			default: begin
				alu_sub = 1'b0;
			end
		endcase
	end

	// control state and accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			filter_q    <= '0;
			acc_count_q <= '0;
			acc_sum_q   <= '0;
			acc_sqs_q   <= '0;
			acc_max_q   <= '0;
			acc_min_q   <= '0;
			acc_sat_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid) filter_q <= cfg.data;
			if (state_q == S_ACC && match) begin
				if (&acc_count_q) begin
					acc_sat_q <= 1'b1;
				end else begin
					if (acc_count_q == '0) begin
						acc_max_q <= t_q;
						acc_min_q <= t_q;
					end else begin
						if (t_q > acc_max_q) acc_max_q <= t_q;
						if (t_q < acc_min_q) acc_min_q <= t_q;
					end
					acc_count_q <= acc_count_q + CNT_W'(1);
					acc_sum_q   <= acc_sum_q + SUM_W'(t_q);
				end
			end
			if (state_q == S_ADD && add_q) acc_sqs_q <= alu_res[SQS_W-1:0];
			if (out_load) begin
				out_valid_q <= 1'b1;
				acc_count_q <= '0;
				acc_sum_q   <= '0;
				acc_sqs_q   <= '0;
				acc_max_q   <= '0;
				acc_min_q   <= '0;
				acc_sat_q   <= 1'b0;
			end else if (result_out.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (in_fire) begin
			nodes_q <= sample_in.data.node_count;
			t_q     <= sample_in.data.sample_time;
			last_q  <= sample_in.data.batch_end;
		end
		case (state_q)
			S_ACC: begin
				sq_q  <= VAR_W'(t_q) * VAR_W'(t_q);
				add_q <= match && !(&acc_count_q);
			end
			S_STAT: begin
				mean_q   <= '0;
				root_q   <= '0;
				work_q   <= PROD_W'(acc_sum_q);
				rem_q    <= '0;
				dvs_q    <= DIV_W'(acc_count_q);
				cnt_q    <= ITER_W'(PROD_W);
				var_ph_q <= 1'b0;
			end
			S_DIV: begin
				rem_q  <= alu_ge ? alu_res[DIV_W-1:0] : div_sh[DIV_W-1:0];
				work_q <= {work_q[PROD_W-2:0], alu_ge};
				cnt_q  <= cnt_q - ITER_W'(1);
				if (last_it) begin
					if (var_ph_q) begin
						rem_q  <= '0;
						root_q <= '0;
						cnt_q  <= ITER_W'(TIME_W);
					end else begin
						mean_q <= {work_q[TIME_W-2:0], alu_ge};
						work_q <= '0;
						mplr_q <= {acc_count_q, {(SUM_W-CNT_W){1'b0}}};
						cnt_q  <= ITER_W'(CNT_W);
					end
				end
			end
			S_MUL_A: begin
				mplr_q <= {mplr_q[SUM_W-2:0], 1'b0};
				cnt_q  <= cnt_q - ITER_W'(1);
				if (last_it) begin
					aux_q  <= alu_res[PROD_W-1:0];
					work_q <= '0;
					mplr_q <= acc_sum_q;
					cnt_q  <= ITER_W'(SUM_W);
				end else begin
					work_q <= alu_res[PROD_W-1:0];
				end
			end
			S_MUL_B: begin
				work_q <= alu_res[PROD_W-1:0];
				mplr_q <= {mplr_q[SUM_W-2:0], 1'b0};
				cnt_q  <= cnt_q - ITER_W'(1);
			end
			S_SUB: begin
				aux_q  <= alu_res[PROD_W-1:0];
				work_q <= '0;
				mplr_q <= {acc_count_q, {(SUM_W-CNT_W){1'b0}}};
				cnt_q  <= ITER_W'(CNT_W);
			end
			S_MUL_C: begin
				mplr_q <= {mplr_q[SUM_W-2:0], 1'b0};
				cnt_q  <= cnt_q - ITER_W'(1);
				if (last_it) begin
					dvs_q    <= alu_res[DIV_W-1:0];
					work_q   <= aux_q;
					rem_q    <= '0;
					cnt_q    <= ITER_W'(PROD_W);
					var_ph_q <= 1'b1;
				end else begin
					work_q <= alu_res[PROD_W-1:0];
				end
			end
			S_SQRT: begin
				rem_q  <= alu_ge ? alu_res[DIV_W-1:0] : sqrt_sh;
				root_q <= {root_q[TIME_W-2:0], alu_ge};
				work_q <= {work_q[PROD_W-3:0], 2'b00};
				cnt_q  <= cnt_q - ITER_W'(1);
			end
			default: begin
				cnt_q <= cnt_q;
			end
		endcase
		if (out_load) begin
			out_q.sample_count    <= acc_count_q;
			out_q.mean_time       <= mean_q;
			out_q.max_time        <= acc_max_q;
			out_q.min_time        <= acc_min_q;
			out_q.std_dev_time    <= root_q;
			out_q.has_samples     <= (acc_count_q != '0);
			out_q.count_saturated <= acc_sat_q;
		end
	end

	a_accept_acc: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> state_q == S_ACC)
		else $error("accepted sample did not enter accumulate");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DIV |-> rem_q < dvs_q)
		else $error("divider remainder not below divisor");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_q.has_samples |->
		out_q.sample_count == '0 && out_q.mean_time == '0 && out_q.std_dev_time == '0)
		else $error("empty batch result not zero");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.has_samples |->
		out_q.min_time <= out_q.mean_time && out_q.mean_time <= out_q.max_time)
		else $error("mean outside min/max");

	a_spread: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.has_samples |->
		out_q.std_dev_time <= out_q.max_time - out_q.min_time)
		else $error("deviation exceeds range");

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the filtered sample statistics unit.
`timescale 1ns / 1ps
module tb_top;
	import fss_pkg::*;

	localparam int LIMIT     = 1_500_000;
	localparam int HOLD_LEN  = 3000;

	class stats_scoreboard;
		bit [FILT_W-1:0] filter;
		bit [CNT_W-1:0]  cnt;
		bit [SUM_W-1:0]  sum;
		bit [SQS_W-1:0]  sq_sum;
		bit [TIME_W-1:0] t_max;
		bit [TIME_W-1:0] t_min;
		bit              sat;
		out_t            expected[$];
		int              errors;
		int              samples;
		int              batches;
		int              empty_batches;
		int              sat_batches;

		function int floor_log2(bit [NODE_W-1:0] v);
			int r;
			r = -1;
			for (int i = 0; i < NODE_W; i++)
				if (v[i]) r = i;
			return r;
		endfunction

		function bit [31:0] int_sqrt(bit [63:0] v);
			bit [31:0] root;
			bit [31:0] trial;
			root = '0;
			for (int i = 31; i >= 0; i--) begin
				trial = root | (32'd1 << i);
				if (64'(trial) * 64'(trial) <= v) root = trial;
			end
			return root;
		endfunction

		function void clear_batch();
			cnt = '0;
			sum = '0;
			sq_sum = '0;
			t_max = '0;
			t_min = '0;
			sat = 1'b0;
		endfunction

		function void note_sample(in_t s);
			bit          hit;
			out_t        r;
			bit [127:0]  num;
			bit [127:0]  den;
			bit [63:0]   var_q;
			samples++;
			hit = (filter == 0) ||
				(s.node_count != 0 && floor_log2(s.node_count) == int'(filter));
			if (hit) begin
				if (cnt == '1) begin
					sat = 1'b1;
				end else begin
					if (cnt == 0) begin
						t_max = s.sample_time;
						t_min = s.sample_time;
					end else begin
						if (s.sample_time > t_max) t_max = s.sample_time;
						if (s.sample_time < t_min) t_min = s.sample_time;
					end
					cnt++;
					sum += SUM_W'(s.sample_time);
					sq_sum += SQS_W'(64'(s.sample_time) * 64'(s.sample_time));
				end
			end
			if (!s.batch_end) return;
			r = '0;
			if (cnt != 0) begin
				r.sample_count = cnt;
				r.mean_time = TIME_W'(sum / SUM_W'(cnt));
				r.max_time = t_max;
				r.min_time = t_min;
				num = 128'(cnt) * 128'(sq_sum) - 128'(sum) * 128'(sum);
				den = 128'(cnt) * 128'(cnt);
				var_q = 64'(num / den);
				r.std_dev_time = TIME_W'(int_sqrt(var_q));
				r.has_samples = 1'b1;
			end else begin
				empty_batches++;
			end
			r.count_saturated = sat;
			if (sat) sat_batches++;
			expected.push_back(r);
			clear_batch();
		endfunction

		function void check_result(out_t got);
			out_t exp_r;
			if (expected.size() == 0) begin
				$error("result with no batch pending");
				errors++;
				return;
			end
			exp_r = expected.pop_front();
			batches++;
			if (got.sample_count !== exp_r.sample_count) begin
				$error("sample_count: expected %0d, got %0d", exp_r.sample_count,
					got.sample_count);
				errors++;
			end
			if (got.mean_time !== exp_r.mean_time) begin
				$error("mean_time: expected %0d, got %0d", exp_r.mean_time, got.mean_time);
				errors++;
			end
			if (got.max_time !== exp_r.max_time) begin
				$error("max_time: expected %0d, got %0d", exp_r.max_time, got.max_time);
				errors++;
			end
			if (got.min_time !== exp_r.min_time) begin
				$error("min_time: expected %0d, got %0d", exp_r.min_time, got.min_time);
				errors++;
			end
			if (got.std_dev_time !== exp_r.std_dev_time) begin
				$error("std_dev_time: expected %0d, got %0d", exp_r.std_dev_time,
					got.std_dev_time);
				errors++;
			end
			if (got.has_samples !== exp_r.has_samples) begin
				$error("has_samples: expected %0b, got %0b", exp_r.has_samples,
					got.has_samples);
				errors++;
			end
			if (got.count_saturated !== exp_r.count_saturated) begin
				$error("count_saturated: expected %0b, got %0b", exp_r.count_saturated,
					got.count_saturated);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	fss_cfg_if filter_ch();
	fss_in_if  sample_ch();
	fss_out_if result_ch();

	filtered_sample_statistics_unit u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (filter_ch),
		.sample_in  (sample_ch),
		.result_out (result_ch)
	);

	stats_scoreboard sb = new();

	int send_idle_pct;
	int recv_stall_pct;
	bit hold_req;
	int hold_left;
	int cycle_cnt;

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		filter_ch.valid = 1'b0;
		filter_ch.data = '0;
		sample_ch.valid = 1'b0;
		sample_ch.data = '0;
		result_ch.ready = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_req = 1'b0;
		hold_left = 0;
		cycle_cnt = 0;
	end

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready) sb.check_result(result_ch.data);
		if (hold_req) begin
			hold_left = HOLD_LEN;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	function automatic in_t mk(bit [NODE_W-1:0] node, bit [TIME_W-1:0] t, bit last);
		in_t s;
		s.node_count = node;
		s.sample_time = t;
		s.batch_end = last;
		return s;
	endfunction

	// node count that matches filter f with the given odds, otherwise anything (a miss at odds 0)
	function automatic bit [NODE_W-1:0] pick_node(bit [FILT_W-1:0] f, int hit_pct);
		bit [NODE_W-1:0] low_mask;
		low_mask = (32'd1 << f) - 32'd1;
		if (f != 0 && $urandom_range(99) < hit_pct)
			return (32'd1 << f) | ($urandom & low_mask);
		if (f != 0 && hit_pct == 0) begin
			case ($urandom_range(2))
				0: return '0;
				1: return 32'd1 << ((f + 1 + $urandom_range(30)) % 32);
				default: return low_mask;
			endcase
		end
		case ($urandom_range(7))
			0: return '0;
			1: return 32'd1;
			2: return '1;
			3: return 32'd1 << $urandom_range(31);
			default: return $urandom;
		endcase
	endfunction

	function automatic bit [TIME_W-1:0] pick_time(int style, bit [TIME_W-1:0] base);
		case (style)
			0: return base;
			1: return $urandom_range(1) ? '1 : '0;
			2: return base + TIME_W'($urandom_range(15));
			default: return TIME_W'($urandom);
		endcase
	endfunction

	task automatic send_sample(in_t s);
		while ($urandom_range(99) < send_idle_pct) begin
			sample_ch.valid <= 1'b0;
			@(posedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.data <= s;
		@(posedge clk);
		while (!sample_ch.ready) @(posedge clk);
		sb.note_sample(s);
	endtask

	task automatic set_filter(bit [FILT_W-1:0] v);
		sample_ch.valid <= 1'b0;
		while (sb.expected.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		filter_ch.valid <= 1'b1;
		filter_ch.data <= v;
		@(posedge clk);
		while (!filter_ch.ready) @(posedge clk);
		filter_ch.valid <= 1'b0;
		sb.filter = v;
	endtask

	task automatic run_random(int idle_pct, int stall_pct, int items, bit hold);
		int sent;
		int seg;
		int len;
		int style;
		int hit_pct;
		bit [FILT_W-1:0] f;
		bit [TIME_W-1:0] base;
		sent = 0;
		seg = 0;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		while (sent < items) begin
			case (seg % 4)
				0: f = '0;
				1: f = '1;
				2: f = FILT_W'(1);
				default: f = FILT_W'($urandom_range(2, 30));
			endcase
			set_filter(f);
			seg++;
			if (hold && seg == 1) hold_req = 1'b1;
			for (int b = 0; b < 8 && sent < items; b++) begin
				case ($urandom_range(9))
					0: len = 1;
					1: len = $urandom_range(40, 80);
					default: len = $urandom_range(2, 20);
				endcase
				style = $urandom_range(5);
				hit_pct = ($urandom_range(11) == 0) ? 0 : 75;
				base = ($urandom_range(3) == 0) ? TIME_W'($urandom_range(255)) :
					TIME_W'($urandom);
				for (int i = 0; i < len; i++) begin
					send_sample(mk(pick_node(f, hit_pct), pick_time(style, base),
						i == len - 1));
					sent++;
				end
			end
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed
		set_filter('0);
		send_sample(mk(32'd0, 24'd0, 1'b1));
		send_sample(mk(32'hFFFF_FFFF, 24'hFF_FFFF, 1'b0));
		send_sample(mk(32'd1, 24'd0, 1'b0));
		send_sample(mk(32'd12345, 24'hFF_FFFF, 1'b1));
		send_sample(mk(32'd7, 24'hFF_FFFF, 1'b1));
		set_filter('1);
		send_sample(mk(32'd0, 24'd100, 1'b1));
		send_sample(mk(32'h8000_0000, 24'hFF_FFFF, 1'b0));
		send_sample(mk(32'hFFFF_FFFF, 24'd0, 1'b0));
		send_sample(mk(32'h7FFF_FFFF, 24'd5, 1'b0));
		send_sample(mk(32'd0, 24'd9, 1'b1));
		set_filter(FILT_W'(1));
		send_sample(mk(32'd2, 24'd10, 1'b0));
		send_sample(mk(32'd3, 24'd20, 1'b0));
		send_sample(mk(32'd1, 24'd30, 1'b0));
		send_sample(mk(32'd4, 24'd40, 1'b1));
		set_filter(FILT_W'(16));
		send_sample(mk(32'h0001_0000, 24'd500, 1'b0));
		send_sample(mk(32'h0001_FFFF, 24'd700, 1'b0));
		send_sample(mk(32'h0000_FFFF, 24'd1, 1'b1));

		run_random(0, 0, 425, 1'b1);
		run_random(48, 0, 425, 1'b0);
		run_random(0, 48, 425, 1'b1);
		run_random(35, 35, 425, 1'b0);

		sample_ch.valid <= 1'b0;
		while (sb.expected.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);

		$display("Checked %0d batch results from %0d samples", sb.batches, sb.samples);
		$display("Empty batches: %0d, saturated batches: %0d", sb.empty_batches,
			sb.sat_batches);
		if (sb.errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/fss_pkg.sv
hdl/fss_if.sv
hdl/filtered_sample_statistics_unit.sv
dv/tb_top.sv
